[rtl/core/dmwf_pkg.sv]
// shared types and constants for the duplicate message window filter
// no dependencies; imported by dmwf_table, dmwf_window and the top level
package dmwf_pkg;

   localparam int DMWF_CACHE_ENTRIES = 8;
   localparam int DMWF_WINDOW_BITS   = 8;
   localparam int DMWF_FUTURE_SPAN   = 8;
   localparam int DMWF_ID_W          = 8;

   // origin as matched in the table, raw 8-bit patterns
   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] z;
      logic [7:0] rot;
   } origin_type;

   typedef enum logic [2:0] {
      VERDICT_NEW_ORIGIN = 3'd0,
      VERDICT_FRESH      = 3'd1,
      VERDICT_OWN        = 3'd2,
      VERDICT_DUPLICATE  = 3'd3,
      VERDICT_TOO_OLD    = 3'd4
   } verdict_type;

   // outcome of the window unit for a matched entry
   typedef struct packed {
      logic                 write;
      logic                 fresh;
      verdict_type          verdict;
      logic [DMWF_ID_W-1:0] base;
   } win_result_type;

endpackage

[rtl/core/dmwf_table.sv]
// origin table: origin key, window base and seen bitmap per entry
// one write port, one registered read port with read enable; uses dmwf_pkg
module dmwf_table #(
   parameter int ENTRIES = dmwf_pkg::DMWF_CACHE_ENTRIES,
   parameter int IDX_W   = 3,
   parameter int MASK_W  = dmwf_pkg::DMWF_WINDOW_BITS
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [IDX_W-1:0]              rd_addr,
   output dmwf_pkg::origin_type          rd_key,
   output logic [dmwf_pkg::DMWF_ID_W-1:0] rd_base,
   output logic [MASK_W-1:0]             rd_mask,
   input  logic                          wr_en,
   input  logic [IDX_W-1:0]              wr_addr,
   input  dmwf_pkg::origin_type          wr_key,
   input  logic [dmwf_pkg::DMWF_ID_W-1:0] wr_base,
   input  logic [MASK_W-1:0]             wr_mask
);
   import dmwf_pkg::*;

   origin_type           key_mem  [ENTRIES];
   logic [DMWF_ID_W-1:0] base_mem [ENTRIES];
   logic [MASK_W-1:0]    mask_mem [ENTRIES];

   origin_type           rd_key_ff;
   logic [DMWF_ID_W-1:0] rd_base_ff;
   logic [MASK_W-1:0]    rd_mask_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]  <= wr_key;
         base_mem[wr_addr] <= wr_base;
         mask_mem[wr_addr] <= wr_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff  <= key_mem[rd_addr];
         rd_base_ff <= base_mem[rd_addr];
         rd_mask_ff <= mask_mem[rd_addr];
      end
   end

   assign rd_key  = rd_key_ff;
   assign rd_base = rd_base_ff;
   assign rd_mask = rd_mask_ff;

endmodule

[rtl/core/dmwf_window.sv]
// window unit: places an id against an entry's base and seen bitmap
// slides the window for ids in the future span; uses dmwf_pkg
module dmwf_window #(
   parameter int MASK_W = dmwf_pkg::DMWF_WINDOW_BITS
) (
   input  logic [dmwf_pkg::DMWF_ID_W-1:0] msg_id,
   input  logic [dmwf_pkg::DMWF_ID_W-1:0] base,
   input  logic [MASK_W-1:0]              mask,
   output dmwf_pkg::win_result_type       res,
   output logic [MASK_W-1:0]              new_mask
);
   import dmwf_pkg::*;

   localparam logic [DMWF_ID_W:0]   WIN_LO  = (DMWF_ID_W+1)'(MASK_W);
   localparam logic [DMWF_ID_W:0]   WIN_HI  = (DMWF_ID_W+1)'(MASK_W + DMWF_FUTURE_SPAN);
   localparam logic [DMWF_ID_W-1:0] WIN_C   = DMWF_ID_W'(MASK_W);
   localparam logic [DMWF_ID_W-1:0] TOP_POS = DMWF_ID_W'(MASK_W - 1);

   logic [DMWF_ID_W-1:0] id_gap;
   logic [DMWF_ID_W:0]   id_gap_ext;
   logic [DMWF_ID_W-1:0] shift;
   logic [DMWF_ID_W-1:0] pos;
   logic                 future;
   logic                 in_win;
   logic                 seen;
   logic [MASK_W-1:0]    eff_mask;
   logic [MASK_W-1:0]    bit_sel;

   assign id_gap     = msg_id - base;
   assign id_gap_ext = {1'b0, id_gap};
   assign future     = (id_gap_ext >= WIN_LO) && (id_gap_ext < WIN_HI);
   assign in_win     = id_gap_ext < WIN_LO;
   // slide so that the id lands in the top bit
   assign shift      = id_gap - WIN_C + DMWF_ID_W'(1);
   assign eff_mask   = future ? (mask >> shift) : mask;
   assign pos        = future ? TOP_POS : id_gap;
   assign bit_sel    = MASK_W'(1) << pos;
   assign seen       = |(eff_mask & bit_sel);
   assign new_mask   = eff_mask | bit_sel;

   always_comb begin
      res.base = future ? (base + shift) : base;
      if (future || in_win) begin
         res.write   = future || !seen;
         res.fresh   = !seen;
         res.verdict = seen ? VERDICT_DUPLICATE : VERDICT_FRESH;
      end else begin
         res.write   = 1'b0;
         res.fresh   = 1'b0;
         res.verdict = VERDICT_TOO_OLD;
      end
   end

endmodule

[rtl/core/duplicate_message_window_filter.sv]
// top level of the duplicate message window filter: sequencer, table, window unit
// depends on dmwf_pkg, dmwf_table and dmwf_window
//
//   channel    | handshake         | payload
//   -----------+-------------------+------------------------------------------------
//   request    | start / busy      | req_msg_id, req_origin_x/_y/_z, req_origin_rot
//   response   | rsp_valid strobe  | rsp_fresh, rsp_verdict
//
// a transaction is taken when start is high and busy is low
// own-module packets are answered straight from idle: busy never rises
// otherwise the table is scanned one entry a cycle through the registered read
// port, up to the matching entry or through all entries in use when none
// matches; the window update or entry allocation follows, and the sequencer
// then returns to idle, where the next transaction can be taken
// the result strobe lasts one cycle and cannot be held off by the receiver
// reset clears the fill count, victim pointer and sequencer; table contents stay
module duplicate_message_window_filter #(
   parameter int CACHE_ENTRIES = dmwf_pkg::DMWF_CACHE_ENTRIES,
   parameter int WINDOW_BITS   = dmwf_pkg::DMWF_WINDOW_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [7:0]        req_msg_id,
   input  logic signed [7:0] req_origin_x,
   input  logic signed [7:0] req_origin_y,
   input  logic signed [7:0] req_origin_z,
   input  logic [7:0]        req_origin_rot,
   output logic              rsp_valid,
   output logic              rsp_fresh,
   output logic [2:0]        rsp_verdict
);
   import dmwf_pkg::*;

   localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(CACHE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CACHE_ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_ALLOC
   } state_type;

   state_type            state_ff,   state_in;
   origin_type           origin_ff,  origin_in;
   logic [DMWF_ID_W-1:0] msg_id_ff,  msg_id_in;
   logic [IDX_W-1:0]     scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]     used_ff,    used_in;
   logic [IDX_W-1:0]     repl_ff,    repl_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_fresh_ff, rsp_fresh_in;
   verdict_type          rsp_verdict_ff, rsp_verdict_in;

   origin_type           req_key;
   logic                 own_module;
   logic                 accept;
   logic [CNT_W-1:0]     scan_next;
   logic                 key_match;
   logic                 last_scan;
   logic                 table_full;

   // table ports
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   origin_type           rd_key;
   logic [DMWF_ID_W-1:0] rd_base;
   logic [WINDOW_BITS-1:0] rd_mask;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [DMWF_ID_W-1:0] wr_base;
   logic [WINDOW_BITS-1:0] wr_mask;

   // window unit
   win_result_type       win_res;
   logic [WINDOW_BITS-1:0] win_mask;

   assign req_key.x   = unsigned'(req_origin_x);
   assign req_key.y   = unsigned'(req_origin_y);
   assign req_key.z   = unsigned'(req_origin_z);
   assign req_key.rot = req_origin_rot;

   // rotation plays no part in the own-module test
   assign own_module = (req_origin_x == 8'sd0) && (req_origin_y == 8'sd0) &&
                       (req_origin_z == 8'sd0);
   assign accept     = start && (state_ff == ST_IDLE);

   assign scan_next  = CNT_W'(scan_idx_ff) + CNT_W'(1);
   assign key_match  = (rd_key == origin_ff);
   assign last_scan  = (scan_next == used_ff);
   assign table_full = (used_ff == DEPTH_CNT);

   dmwf_table #(
      .ENTRIES (CACHE_ENTRIES),
      .IDX_W   (IDX_W),
      .MASK_W  (WINDOW_BITS)
   ) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_key  (rd_key),
      .rd_base (rd_base),
      .rd_mask (rd_mask),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_key  (origin_ff),
      .wr_base (wr_base),
      .wr_mask (wr_mask)
   );

   dmwf_window #(
      .MASK_W   (WINDOW_BITS)
   ) u_window (
      .msg_id   (msg_id_ff),
      .base     (rd_base),
      .mask     (rd_mask),
      .res      (win_res),
      .new_mask (win_mask)
   );

   // read side: idle keeps entry 0 loaded so the first compare follows acceptance
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      case (state_ff)
         ST_IDLE: begin
            rd_en = 1'b1;
         end
         ST_SCAN: begin
            // hold the matching entry for the update cycle
            rd_en = !key_match;
            if (scan_next < DEPTH_CNT) begin
               rd_addr = IDX_W'(scan_next);
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // write side and sequencer
   always_comb begin
      state_in       = state_ff;
      origin_in      = origin_ff;
      msg_id_in      = msg_id_ff;
      scan_idx_in    = scan_idx_ff;
      used_in        = used_ff;
      repl_in        = repl_ff;
      rsp_valid_in   = 1'b0;
      rsp_fresh_in   = rsp_fresh_ff;
      rsp_verdict_in = rsp_verdict_ff;
      wr_en          = 1'b0;
      wr_addr        = scan_idx_ff;
      wr_base        = win_res.base;
      wr_mask        = win_mask;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (own_module) begin
                  rsp_valid_in   = 1'b1;
                  rsp_fresh_in   = 1'b0;
                  rsp_verdict_in = VERDICT_OWN;
               end else begin
                  origin_in   = req_key;
                  msg_id_in   = req_msg_id;
                  scan_idx_in = '0;
                  state_in    = (used_ff == '0) ? ST_ALLOC : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (key_match) begin
               state_in = ST_UPDATE;
            end else if (last_scan) begin
               state_in = ST_ALLOC;
            end else begin
               scan_idx_in = IDX_W'(scan_next);
            end
         end
         ST_UPDATE: begin
            wr_en          = win_res.write;
            rsp_valid_in   = 1'b1;
            rsp_fresh_in   = win_res.fresh;
            rsp_verdict_in = win_res.verdict;
            state_in       = ST_IDLE;
         end
         ST_ALLOC: begin
            // free entry while filling, round-robin victim once full
            wr_en   = 1'b1;
            wr_base = msg_id_ff;
            wr_mask = WINDOW_BITS'(1);
            if (table_full) begin
               wr_addr = repl_ff;
               repl_in = (repl_ff == LAST_IDX) ? '0 : (repl_ff + IDX_W'(1));
            end else begin
               wr_addr = IDX_W'(used_ff);
               used_in = used_ff + CNT_W'(1);
            end
            rsp_valid_in   = 1'b1;
            rsp_fresh_in   = 1'b1;
            rsp_verdict_in = VERDICT_NEW_ORIGIN;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         repl_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         repl_ff      <= repl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // transaction payload, no reset needed
      origin_ff      <= origin_in;
      msg_id_ff      <= msg_id_in;
      scan_idx_ff    <= scan_idx_in;
      rsp_fresh_ff   <= rsp_fresh_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_fresh   = rsp_fresh_ff;
   assign rsp_verdict = rsp_verdict_ff;

endmodule

[tb/duplicate_message_window_filter_tb.sv]
// self-checking testbench for duplicate_message_window_filter
// needs dmwf_pkg and the filter rtl; a scoreboard class predicts each verdict
`timescale 1ns / 1ps

module duplicate_message_window_filter_tb;
   import dmwf_pkg::*;

   localparam int NUM_RANDOM   = 400;
   localparam int CALM_TAIL    = 60;   // last random items with no idling
   localparam int POOL_SIZE    = 12;   // more origins than table entries
   localparam int STALL_LIMIT  = 300;  // cycles with no transaction at all
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_MAX   = 10;

   // one expected response
   typedef struct {
      logic        fresh;
      verdict_type verdict;
   } verdict_rec_type;

   // shadow copy of the origin table and the queue of verdicts still owed
   class verdict_scoreboard;
      origin_type                  entry_origin [DMWF_CACHE_ENTRIES];
      logic [DMWF_ID_W-1:0]        entry_base   [DMWF_CACHE_ENTRIES];
      logic [DMWF_WINDOW_BITS-1:0] entry_seen   [DMWF_CACHE_ENTRIES];
      int unsigned                 used_count   = 0;
      int unsigned                 victim       = 0;
      verdict_rec_type             expected_verdicts [$];
      int unsigned                 mismatch_count = 0;

      // work out the verdict of an accepted packet and update the shadow table
      function void note_packet(logic [DMWF_ID_W-1:0] id, origin_type o);
         verdict_rec_type      rec;
         logic [DMWF_ID_W-1:0] id_gap;
         int unsigned          shift;
         int unsigned          slot;
         bit                   hit;
         hit = 0;
         if (o.x == 8'h00 && o.y == 8'h00 && o.z == 8'h00) begin
            rec.fresh   = 1'b0;
            rec.verdict = VERDICT_OWN;
            hit = 1;
         end
         for (int i = 0; i < used_count && !hit; i++) begin
            if (entry_origin[i] == o) begin
               hit    = 1;
               id_gap = id - entry_base[i];
               // id just ahead of the window: slide so it lands in the top bit
               if (id_gap >= DMWF_WINDOW_BITS &&
                   id_gap < DMWF_WINDOW_BITS + DMWF_FUTURE_SPAN) begin
                  shift         = id_gap - DMWF_WINDOW_BITS + 1;
                  entry_seen[i] = entry_seen[i] >> shift;
                  entry_base[i] = entry_base[i] + shift[DMWF_ID_W-1:0];
                  id_gap        = DMWF_ID_W'(DMWF_WINDOW_BITS - 1);
               end
               if (id_gap < DMWF_WINDOW_BITS) begin
                  if (entry_seen[i][id_gap]) begin
                     rec.fresh   = 1'b0;
                     rec.verdict = VERDICT_DUPLICATE;
                  end else begin
                     entry_seen[i][id_gap] = 1'b1;
                     rec.fresh   = 1'b1;
                     rec.verdict = VERDICT_FRESH;
                  end
               end else begin
                  rec.fresh   = 1'b0;
                  rec.verdict = VERDICT_TOO_OLD;
               end
            end
         end
         if (!hit) begin
            // unknown origin: free entry first, then round-robin replacement
            if (used_count < DMWF_CACHE_ENTRIES) begin
               slot = used_count;
               used_count++;
            end else begin
               slot   = victim;
               victim = (victim + 1) % DMWF_CACHE_ENTRIES;
            end
            entry_origin[slot] = o;
            entry_base[slot]   = id;
            entry_seen[slot]   = DMWF_WINDOW_BITS'(1);
            rec.fresh   = 1'b1;
            rec.verdict = VERDICT_NEW_ORIGIN;
         end
         expected_verdicts.push_back(rec);
      endfunction

      // compare a response against the oldest verdict owed
      function void check_verdict(logic fresh, logic [2:0] verdict);
         verdict_rec_type rec;
         if (expected_verdicts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("%0t: response with none owed: fresh %b verdict %0d",
                        $realtime, fresh, verdict);
         end else begin
            rec = expected_verdicts.pop_front();
            if (fresh !== rec.fresh || verdict !== rec.verdict) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("%0t: mismatch: exp fresh %b verdict %0d, got fresh %b verdict %0d",
                           $realtime, rec.fresh, rec.verdict, fresh, verdict);
            end
         end
      endfunction

      function int unsigned pending_count();
         return expected_verdicts.size();
      endfunction

      // mismatches plus any verdict never answered
      function int unsigned failures();
         return mismatch_count + expected_verdicts.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [7:0]        req_msg_id     = '0;
   logic signed [7:0] req_origin_x   = '0;
   logic signed [7:0] req_origin_y   = '0;
   logic signed [7:0] req_origin_z   = '0;
   logic [7:0]        req_origin_rot = '0;
   logic              rsp_valid;
   logic              rsp_fresh;
   logic [2:0]        rsp_verdict;

   verdict_scoreboard sb = new;
   int unsigned       quiet_cycles = 0;

   duplicate_message_window_filter u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_msg_id     (req_msg_id),
      .req_origin_x   (req_origin_x),
      .req_origin_y   (req_origin_y),
      .req_origin_z   (req_origin_z),
      .req_origin_rot (req_origin_rot),
      .rsp_valid      (rsp_valid),
      .rsp_fresh      (rsp_fresh),
      .rsp_verdict    (rsp_verdict)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 0;
   end

   // monitor: note the request transaction first, so a same-edge response finds it
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_packet(req_msg_id,
                           '{x: req_origin_x, y: req_origin_y, z: req_origin_z,
                             rot: req_origin_rot});
         if (rsp_valid)
            sb.check_verdict(rsp_fresh, rsp_verdict);
         if ((start && !busy) || rsp_valid)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // watchdog: nothing moving for too long means a hang
   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   // present one packet and hold it until the block takes it; start stays high
   task automatic send_packet(input logic [7:0] id, input origin_type o);
      start          <= 1'b1;
      req_msg_id     <= id;
      req_origin_x   <= o.x;
      req_origin_y   <= o.y;
      req_origin_z   <= o.z;
      req_origin_rot <= o.rot;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // sender gap, with junk on the payload while start is low
   task automatic idle_for(input int unsigned n);
      start          <= 1'b0;
      req_msg_id     <= 8'($urandom);
      req_origin_x   <= 8'($urandom);
      req_origin_y   <= 8'($urandom);
      req_origin_z   <= 8'($urandom);
      req_origin_rot <= 8'($urandom);
      repeat (n) @(posedge clock);
   endtask

   initial begin
      origin_type  org_a;
      origin_type  org_b;
      origin_type  o;
      origin_type  pool    [POOL_SIZE];
      logic [7:0]  pool_id [POOL_SIZE];
      logic [7:0]  id;
      int unsigned roll;
      int unsigned p;
      bit          calm;

      org_a = '{x: 8'h80, y: 8'h7f, z: 8'hff, rot: 8'hff};
      org_b = '{x: 8'h00, y: 8'h00, z: 8'h01, rot: 8'h00};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // own module, both rotation extremes
      send_packet(8'h00, '{x: 8'h00, y: 8'h00, z: 8'h00, rot: 8'h00});
      send_packet(8'hff, '{x: 8'h00, y: 8'h00, z: 8'h00, rot: 8'hff});
      // new origin at field extremes, then a repeat of the same id
      send_packet(8'hff, org_a);
      send_packet(8'hff, org_a);
      // ids inside the window, wrapping past 255, up to its top bit
      send_packet(8'h00, org_a);
      send_packet(8'h06, org_a);
      // one past the window: slide by one
      send_packet(8'h07, org_a);
      // far end of the future span: slide clears the whole bitmap
      send_packet(8'h0f, org_a);
      send_packet(8'h0f, org_a);
      idle_for(3);
      // just behind the window, and just past the future span
      send_packet(8'h07, org_a);
      send_packet(8'h18, org_a);
      send_packet(8'h17, org_a);
      // a single nonzero coordinate is not the own module
      send_packet(8'h00, org_b);
      // same position with another rotation is a different origin
      send_packet(8'h00, '{x: 8'h80, y: 8'h7f, z: 8'hff, rot: 8'h00});
      // fill the table
      send_packet(8'h10, '{x: 8'h01, y: 8'h00, z: 8'h00, rot: 8'h33});
      send_packet(8'h20, '{x: 8'h00, y: 8'h01, z: 8'h00, rot: 8'hcc});
      send_packet(8'h80, '{x: 8'h7f, y: 8'h80, z: 8'h01, rot: 8'h55});
      send_packet(8'h7f, '{x: 8'hff, y: 8'hff, z: 8'hff, rot: 8'haa});
      send_packet(8'h42, '{x: 8'h12, y: 8'h34, z: 8'h56, rot: 8'h78});
      idle_for(1);
      // table full: round-robin replacement evicts the oldest entries
      send_packet(8'h99, '{x: 8'hc3, y: 8'h3c, z: 8'h5a, rot: 8'ha5});
      send_packet(8'h17, org_a);
      send_packet(8'h05, org_b);

      for (int i = 0; i < POOL_SIZE; i++) begin
         pool[i] = origin_type'($urandom);
         if (pool[i].x == 8'h00 && pool[i].y == 8'h00 && pool[i].z == 8'h00)
            pool[i].x = 8'h01;
         pool_id[i] = 8'($urandom);
      end

      calm = 0;
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n % 40 == 0)
            calm = ($urandom_range(0, 2) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            o   = '{x: 8'h00, y: 8'h00, z: 8'h00, rot: 8'($urandom)};
            id  = 8'($urandom);
         end else if (roll < 16) begin
            o   = origin_type'($urandom);
            id  = 8'($urandom);
         end else begin
            // mostly a hot set that fits the table, sometimes the whole pool
            if ($urandom_range(0, 3) == 0)
               p = $urandom_range(0, POOL_SIZE - 1);
            else
               p = $urandom_range(0, 5);
            o    = pool[p];
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
               id = 8'($urandom);
            end else if (roll < 3) begin
               id = pool_id[p] - 8'($urandom_range(0, 9));
            end else begin
               id         = pool_id[p] + 8'($urandom_range(0, 17));
               pool_id[p] = id;
            end
         end
         send_packet(id, o);
         if (!calm && n < NUM_RANDOM - CALM_TAIL && $urandom_range(0, 2) == 0)
            idle_for($urandom_range(1, 15));
      end

      start <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
